FILE: rtl/idll_pkg.sv
// Shared types and constants of the indexed doubly linked list core.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package idll_pkg;

  // Fixed field widths of the request and result transfers.
  localparam int unsigned OP_W     = 4;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD_FIRST    = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD_LAST     = 4'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 4'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_LAST  = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_GET_AT       = 4'd6;
  localparam logic [OP_W-1:0] OP_SET_AT       = 4'd7;
  localparam logic [OP_W-1:0] OP_GET_FIRST    = 4'd8;
  localparam logic [OP_W-1:0] OP_GET_LAST     = 4'd9;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_CHECK,
    CMD_WALK_RD,
    CMD_WALK_STEP,
    CMD_SET_APPEND,
    CMD_CAP_PRV,
    CMD_RD_FREE,
    CMD_ALLOC,
    CMD_INS_W1,
    CMD_INS_W2,
    CMD_CAP_NODE,
    CMD_RM_W1,
    CMD_RM_W2,
    CMD_CAP_VAL,
    CMD_LOAD_OUT
  } dp_cmd_e;

  // Status flags returned from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic nop;
    logic is_ins;
    logic is_rm;
    logic append;
    logic walk_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/idll_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the value and link stores of the list core.
`default_nettype none

module idll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/idll_ctrl.sv
// Controller state machine of the list core: sequences each request.
// Depends on idll_pkg for the command and status types.
`default_nettype none

module idll_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  output      logic                 req_ready_o,
  input  wire idll_pkg::dp_status_t status_i,
  output      idll_pkg::dp_cmd_e    cmd_o
);
  import idll_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_WALK     = 4'd2;
  localparam logic [3:0] S_WALK_W   = 4'd3;
  localparam logic [3:0] S_PRV_RD   = 4'd4;
  localparam logic [3:0] S_PRV_CAP  = 4'd5;
  localparam logic [3:0] S_FREE_RD  = 4'd6;
  localparam logic [3:0] S_ALLOC    = 4'd7;
  localparam logic [3:0] S_INS_W1   = 4'd8;
  localparam logic [3:0] S_INS_W2   = 4'd9;
  localparam logic [3:0] S_NODE_RD  = 4'd10;
  localparam logic [3:0] S_RM_CAP   = 4'd11;
  localparam logic [3:0] S_RM_W1    = 4'd12;
  localparam logic [3:0] S_RM_W2    = 4'd13;
  localparam logic [3:0] S_VAL_CAP  = 4'd14;
  localparam logic [3:0] S_RESULT   = 4'd15;

  logic [3:0] state_q, state_d;

  // Next state and command for the datapath.
  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o   = CMD_LATCH;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o = CMD_CHECK;
        if (status_i.err || status_i.nop) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (!status_i.walk_done) begin
          cmd_o   = CMD_WALK_RD;
          state_d = S_WALK_W;
        end else if (status_i.is_ins && status_i.append) begin
          cmd_o   = CMD_SET_APPEND;
          state_d = S_FREE_RD;
        end else if (status_i.is_ins) begin
          state_d = S_PRV_RD;
        end else begin
          state_d = S_NODE_RD;
        end
      end
      S_WALK_W: begin
        cmd_o   = CMD_WALK_STEP;
        state_d = S_WALK;
      end
      S_PRV_RD: begin
        state_d = S_PRV_CAP;
      end
      S_PRV_CAP: begin
        cmd_o   = CMD_CAP_PRV;
        state_d = S_FREE_RD;
      end
      S_FREE_RD: begin
        cmd_o   = CMD_RD_FREE;
        state_d = S_ALLOC;
      end
      S_ALLOC: begin
        cmd_o   = CMD_ALLOC;
        state_d = S_INS_W1;
      end
      S_INS_W1: begin
        cmd_o   = CMD_INS_W1;
        state_d = S_INS_W2;
      end
      S_INS_W2: begin
        cmd_o   = CMD_INS_W2;
        state_d = S_RESULT;
      end
      S_NODE_RD: begin
        state_d = status_i.is_rm ? S_RM_CAP : S_VAL_CAP;
      end
      S_RM_CAP: begin
        cmd_o   = CMD_CAP_NODE;
        state_d = S_RM_W1;
      end
      S_RM_W1: begin
        cmd_o   = CMD_RM_W1;
        state_d = S_RM_W2;
      end
      S_RM_W2: begin
        cmd_o   = CMD_RM_W2;
        state_d = S_RESULT;
      end
      S_VAL_CAP: begin
        cmd_o   = CMD_CAP_VAL;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o   = CMD_LOAD_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/idll_datapath.sv
// Datapath of the list core: list registers, link and value stores, walk
// cursor and result register. Depends on idll_pkg and idll_ram.
`default_nettype none

module idll_datapath #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire idll_pkg::dp_cmd_e               cmd_i,
  output      idll_pkg::dp_status_t            status_o,
  input  wire logic [idll_pkg::OP_W-1:0]       op_i,
  input  wire logic [idll_pkg::POS_W-1:0]      pos_i,
  input  wire logic [idll_pkg::ITEM_W-1:0]     item_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [idll_pkg::RES_W-1:0]      out_result_o,
  output      logic [idll_pkg::STATUS_W-1:0]   out_status_o,
  output      logic [idll_pkg::COUNT_W-1:0]    out_count_o,
  output      logic                            out_empty_o
);
  import idll_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned LW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (LW > POS_W) ? LW : POS_W;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  // Request and list registers.
  logic [OP_W-1:0]        op_q;
  logic [POS_W-1:0]       pos_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [STATUS_W-1:0]    st_q;
  logic [VALUE_WIDTH-1:0] res_q;
  logic [LW-1:0]          first_q, last_q, rec_head_q, fresh_q, count_q;
  logic [LW-1:0]          cur_q, nxt_q, prv_q, x_q;
  logic [POS_W-1:0]       walk_q, limit_q;
  logic                   out_valid_q;
  logic [RES_W-1:0]       out_result_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [COUNT_W-1:0]     out_count_q;
  logic                   out_empty_q;

  // Store ports.
  logic                   fwd_we, bwd_we, val_we;
  logic [AW-1:0]          fwd_waddr, bwd_waddr, val_waddr, fwd_raddr;
  logic [LW-1:0]          fwd_wdata, bwd_wdata, fwd_rdata, bwd_rdata;
  logic [VALUE_WIDTH-1:0] val_rdata;

  // Request classification.
  logic [CMPW-1:0]     pos_ext, cnt_ext;
  logic                full, empty, positional, is_ins, is_rm, is_set, nop, append;
  logic [STATUS_W-1:0] st_c;

  assign pos_ext    = CMPW'(pos_q);
  assign cnt_ext    = CMPW'(count_q);
  assign full       = (count_q >= NIL);
  assign empty      = (count_q == '0);
  assign is_ins     = (op_q == OP_ADD_FIRST) || (op_q == OP_ADD_LAST) ||
                      (op_q == OP_INSERT_AT);
  assign is_rm      = (op_q == OP_REMOVE_FIRST) || (op_q == OP_REMOVE_LAST) ||
                      (op_q == OP_REMOVE_AT);
  assign is_set     = (op_q == OP_SET_AT);
  assign nop        = (op_q > OP_GET_LAST);
  assign append     = (op_q == OP_ADD_LAST) ||
                      ((op_q == OP_INSERT_AT) && (pos_ext == cnt_ext)) ||
                      ((op_q == OP_ADD_FIRST) && empty);

  always_comb begin
    case (op_q)
      OP_ADD_FIRST, OP_ADD_LAST: st_c = full ? ST_FULL : ST_OK;
      OP_INSERT_AT: begin
        if (pos_ext > cnt_ext) begin
          st_c = ST_BAD_POS;
        end else if (full) begin
          st_c = ST_FULL;
        end else begin
          st_c = ST_OK;
        end
      end
      OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_GET_FIRST, OP_GET_LAST:
        st_c = empty ? ST_EMPTY : ST_OK;
      OP_REMOVE_AT, OP_GET_AT, OP_SET_AT:
        st_c = (pos_ext >= cnt_ext) ? ST_BAD_POS : ST_OK;
      default: st_c = ST_OK;
    endcase
  end

  // Positional operations walk to their position; end operations start there.
  assign positional = (op_i == OP_INSERT_AT) || (op_i == OP_REMOVE_AT) ||
                      (op_i == OP_GET_AT) || (op_i == OP_SET_AT);

  assign status_o.err       = (st_c != ST_OK);
  assign status_o.nop       = nop;
  assign status_o.is_ins    = is_ins;
  assign status_o.is_rm     = is_rm;
  assign status_o.append    = append;
  assign status_o.walk_done = (walk_q == limit_q);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // Store write and read address decode.
  always_comb begin
    fwd_we    = 1'b0;
    bwd_we    = 1'b0;
    val_we    = 1'b0;
    fwd_waddr = x_q[AW-1:0];
    fwd_wdata = nxt_q;
    bwd_waddr = x_q[AW-1:0];
    bwd_wdata = prv_q;
    val_waddr = x_q[AW-1:0];
    fwd_raddr = (cmd_i == CMD_RD_FREE) ? rec_head_q[AW-1:0] : cur_q[AW-1:0];
    unique case (cmd_i)
      CMD_INS_W1: begin
        fwd_we = 1'b1;
        bwd_we = 1'b1;
        val_we = 1'b1;
      end
      CMD_INS_W2: begin
        fwd_we    = (prv_q != NIL);
        fwd_waddr = prv_q[AW-1:0];
        fwd_wdata = x_q;
        bwd_we    = (nxt_q != NIL);
        bwd_waddr = nxt_q[AW-1:0];
        bwd_wdata = x_q;
      end
      CMD_RM_W1: begin
        fwd_we    = (prv_q != NIL);
        fwd_waddr = prv_q[AW-1:0];
        fwd_wdata = nxt_q;
        bwd_we    = (nxt_q != NIL);
        bwd_waddr = nxt_q[AW-1:0];
        bwd_wdata = prv_q;
      end
      CMD_RM_W2: begin
        fwd_we    = 1'b1;
        fwd_waddr = cur_q[AW-1:0];
        fwd_wdata = rec_head_q;
      end
      CMD_CAP_VAL: begin
        val_we    = is_set;
        val_waddr = cur_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  idll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .raddr_i (fwd_raddr),
    .rdata_o (fwd_rdata)
  );

  idll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_bwd_ram (
    .clk_i   (clk_i),
    .we_i    (bwd_we),
    .waddr_i (bwd_waddr),
    .wdata_i (bwd_wdata),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (bwd_rdata)
  );

  idll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (val_rdata)
  );

  // Payload registers of the request in flight.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LATCH: begin
        op_q    <= op_i;
        pos_q   <= pos_i;
        val_q   <= VALUE_WIDTH'(item_i);
        res_q   <= '0;
        walk_q  <= '0;
        limit_q <= positional ? pos_i : '0;
        cur_q   <= ((op_i == OP_REMOVE_LAST) || (op_i == OP_GET_LAST)) ? last_q : first_q;
      end
      CMD_CHECK:      st_q   <= st_c;
      CMD_WALK_STEP: begin
        cur_q  <= fwd_rdata;
        walk_q <= walk_q + 1'b1;
      end
      CMD_SET_APPEND: begin
        nxt_q <= NIL;
        prv_q <= last_q;
      end
      CMD_CAP_PRV: begin
        nxt_q <= cur_q;
        prv_q <= bwd_rdata;
      end
      CMD_ALLOC:      x_q    <= (rec_head_q != NIL) ? rec_head_q : fresh_q;
      CMD_CAP_NODE: begin
        nxt_q <= fwd_rdata;
        prv_q <= bwd_rdata;
        res_q <= val_rdata;
      end
      CMD_CAP_VAL:    res_q  <= val_rdata;
      default: begin
      end
    endcase
  end

  // List control registers; untouched slots are handed out in order from
  // fresh_q, recycled slots are chained from rec_head_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= NIL;
      last_q     <= NIL;
      rec_head_q <= NIL;
      fresh_q    <= '0;
      count_q    <= '0;
    end else begin
      unique case (cmd_i)
        CMD_ALLOC: begin
          if (rec_head_q != NIL) begin
            rec_head_q <= fwd_rdata;
          end else begin
            fresh_q <= fresh_q + 1'b1;
          end
        end
        CMD_INS_W2: begin
          if (prv_q == NIL) first_q <= x_q;
          if (nxt_q == NIL) last_q <= x_q;
          count_q <= count_q + 1'b1;
        end
        CMD_RM_W1: begin
          if (prv_q == NIL) first_q <= nxt_q;
          if (nxt_q == NIL) last_q <= prv_q;
        end
        CMD_RM_W2: begin
          rec_head_q <= cur_q;
          count_q    <= count_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register; a result waits here while the next request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_LOAD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD_OUT) begin
      out_result_q <= RES_W'(res_q);
      out_status_q <= st_q;
      out_count_q  <= COUNT_W'(count_q);
      out_empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_result_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;
  assign out_empty_o  = out_empty_q;

  // A link-in only happens while a slot is left.
  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_INS_W2) |-> (count_q < NIL))
    else $error("insert completed on a full store");

  // An unlink only happens on a non-empty list.
  a_rm_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_RM_W2) |-> (count_q != '0))
    else $error("remove completed on an empty list");

  // A loaded result carries the count after the request and a matching flag.
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_LOAD_OUT) |=> (out_valid_q && (out_empty_q == (out_count_q == '0))))
    else $error("result count and empty flag disagree");

endmodule

`default_nettype wire

FILE: rtl/indexed_doubly_linked_list_core.sv
// Top level of the indexed doubly linked list core: stream ports around
// the controller and datapath. Depends on idll_pkg, idll_ctrl, idll_datapath.
`default_nettype none

// Bounded doubly linked list of up to CAPACITY values held in slot stores.
// Each request transfer gives exactly one result transfer. Requests are
// handled one at a time. Of the end operations a get is quickest, a remove
// or an append slower, and an insert in front of an existing node, which
// first reads that node's back link, the slowest. A rejected or unused
// request goes straight from the check to its result. Positional operations
// first walk from the front, reading one forward link per step through the
// registered read port of the link store, one step per link followed.
// The input is ready again in the cycle after a result is loaded. A result
// waits in the output register while the next request is already taken.
// No clearing pass runs after reset: untouched slots are handed out in
// order, so the block accepts requests from the first cycle.
module indexed_doubly_linked_list_core #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output      logic                               s_axis_tready_o,
  // tdata: position [8:0], item_value [40:9], zero fill [47:41]
  input  wire logic [idll_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: operation [3:0]
  input  wire logic [idll_pkg::OP_W-1:0]          s_axis_tuser_i,
  output      logic                               m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata: result_value [31:0], status [33:32], element_count [42:34],
  // is_empty [43], zero fill [47:44]
  output      logic [idll_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import idll_pkg::*;

  dp_cmd_e             cmd;
  dp_status_t          status;
  logic [RES_W-1:0]    out_result;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  logic                out_empty;

  idll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  idll_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (s_axis_tuser_i),
    .pos_i        (s_axis_tdata_i[POS_W-1:0]),
    .item_i       (s_axis_tdata_i[POS_W+ITEM_W-1:POS_W]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_o (out_result),
    .out_status_o (out_status),
    .out_count_o  (out_count),
    .out_empty_o  (out_empty)
  );

  // Pack the result fields from the lowest bit up.
  assign m_axis_tdata_o = {4'b0000, out_empty, out_count, out_status, out_result};

endmodule

`default_nettype wire
